[src/css_color_string_parser_assert.svh]
// assertion macros for the css color string parser
`ifndef CSS_COLOR_STRING_PARSER_ASSERT_SVH
`define CSS_COLOR_STRING_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CSSP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define CSSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CSSP_ASSERT_NOW(name, ante, cons)
`define CSSP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[src/cssp_pkg.sv]
`default_nettype none

package cssp_pkg;

    localparam int FRACTION_DIGITS = 4;
    localparam longint FRAC_SCALE = 10 ** FRACTION_DIGITS;
    localparam int FRAC_W = $clog2(FRAC_SCALE);
    localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);
    localparam int WT_W = FRAC_W + 4;

    // alpha = floor(frac * 255 / FRAC_SCALE) by multiply with reciprocal
    localparam longint ALPHA_XMAX = (FRAC_SCALE - 1) * 255;
    localparam int ALPHA_SHIFT = $clog2(ALPHA_XMAX * FRAC_SCALE);
    localparam longint ALPHA_MAGIC =
        ((longint'(1) << ALPHA_SHIFT) + FRAC_SCALE - 1) / FRAC_SCALE;
    localparam longint ALPHA_K = ALPHA_MAGIC * 255;
    localparam int K_W = $clog2(ALPHA_K + 1);
    localparam int PROD_W = FRAC_W + K_W;

    localparam int NAME_COUNT = 16;
    localparam int MASK_RGB = 16;
    localparam int MASK_RGBA = 17;
    localparam int MASK_W = 18;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [31:0] PREFIX_RGB = "rgb(";
    localparam logic [39:0] PREFIX_RGBA = "rgba(";

    localparam logic [63:0] NAME_STR [NAME_COUNT] = '{
        "maroon", "red", "orange", "yellow", "olive", "purple", "fuschia", "white",
        "lime", "green", "navy", "blue", "aqua", "teal", "silver", "gray"
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd6, 4'd3, 4'd6, 4'd6, 4'd5, 4'd6, 4'd7, 4'd5,
        4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4
    };
    localparam logic [23:0] NAME_RGB [NAME_COUNT] = '{
        24'h800000, 24'hFF0000, 24'hFFA500, 24'hFFFF00,
        24'h808000, 24'h800080, 24'hFF00FF, 24'hFFFFFF,
        24'h00FF00, 24'h008000, 24'h000080, 24'h0000FF,
        24'h00FFFF, 24'h008080, 24'hC0C0C0, 24'h808080
    };

    typedef enum logic [2:0] {
        FORM_HEX6  = 3'd0,
        FORM_HEX3  = 3'd1,
        FORM_NAMED = 3'd2,
        FORM_RGB   = 3'd3,
        FORM_RGBA  = 3'd4,
        FORM_BLACK = 3'd5
    } form_t;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        form_t             form;
        logic              alpha_full;
        logic [FRAC_W-1:0] alpha_frac;
    } fin_t;

    function automatic logic [7:0] name_char(input int idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos < NAME_LEN[idx]) begin
            ch = NAME_STR[idx][8 * (int'(NAME_LEN[idx]) - 1 - int'(pos)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c <= CH_UPPER_Z) begin
            v = c - 8'd55;
        end else begin
            v = c - 8'd87;
        end
        return v;
    endfunction

    // place value of the next fraction digit, fraction kept at full scale
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        int w;
        w = 1;
        for (int i = 1; i < FRACTION_DIGITS; i++) begin
            if (i + int'(cnt) < FRACTION_DIGITS) begin
                w = w * 10;
            end
        end
        return FRAC_W'(w);
    endfunction

endpackage

`default_nettype wire

[src/cssp_scan.sv]
`default_nettype none

module cssp_scan
    import cssp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       char_valid,
    input  wire logic [7:0] char_code,
    input  wire logic       char_last,
    output fin_t            fin
);

    logic [3:0]        pos_reg, pos_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              hash_reg, hash_next;
    logic [7:0]        nib_reg [6];
    logic [7:0]        nib_next [6];
    logic [7:0]        comp_reg [3];
    logic [7:0]        comp_next [3];
    logic [1:0]        idx_reg, idx_next;
    logic              run_reg, run_next;
    logic              whole_nz_reg, whole_nz_next;
    logic              point_reg, point_next;
    logic              done_reg, done_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              digit;
    logic [3:0]        dval;
    logic [11:0]       acc;
    logic [WT_W-1:0]   weighted;
    logic [2:0]        nib_idx;
    logic [4:0]        len_now;
    logic              named_hit;
    logic [23:0]       named_rgb;

    always_comb begin
        pos_next      = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
        mask_next     = mask_reg;
        hash_next     = hash_reg | (pos_reg == 4'd0 && char_code == CH_HASH);
        nib_next      = nib_reg;
        comp_next     = comp_reg;
        idx_next      = idx_reg;
        run_next      = run_reg;
        whole_nz_next = whole_nz_reg;
        point_next    = point_reg;
        done_next     = done_reg;
        frac_next     = frac_reg;
        cnt_next      = cnt_reg;
        digit         = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        dval          = char_code[3:0];
        acc           = 12'(comp_reg[idx_reg]) * 12'd10 + 12'(dval);
        weighted      = WT_W'(dval) * WT_W'(frac_weight(cnt_reg));
        nib_idx       = 3'(pos_reg - 4'd1);

        if (pos_reg >= 4'd1 && pos_reg <= 4'd6) begin
            nib_next[nib_idx] = hex_value(char_code);
        end

        for (int i = 0; i < NAME_COUNT; i++) begin
            if (pos_reg >= NAME_LEN[i] || name_char(i, pos_reg) != char_code) begin
                mask_next[i] = 1'b0;
            end
        end
        if (pos_reg < 4'd4) begin
            if (PREFIX_RGB[8 * (3 - int'(pos_reg)) +: 8] != char_code) begin
                mask_next[MASK_RGB] = 1'b0;
            end
        end
        if (pos_reg < 4'd5) begin
            if (PREFIX_RGBA[8 * (4 - int'(pos_reg)) +: 8] != char_code) begin
                mask_next[MASK_RGBA] = 1'b0;
            end
        end

        // decimal runs for red, green, blue, then the alpha number
        if (idx_reg != 2'd3) begin
            if (digit) begin
                if (run_reg) begin
                    comp_next[idx_reg] = (acc > 12'd255) ? 8'hFF : acc[7:0];
                end else begin
                    comp_next[idx_reg] = 8'(dval);
                    run_next = 1'b1;
                end
            end else if (run_reg) begin
                run_next = 1'b0;
                idx_next = idx_reg + 2'd1;
            end
        end else if (mask_next[MASK_RGBA] && !done_reg) begin
            if (point_reg) begin
                if (digit) begin
                    if (cnt_reg < CNT_W'(FRACTION_DIGITS)) begin
                        frac_next = frac_reg + weighted[FRAC_W-1:0];
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    done_next = 1'b1;
                end
            end else if (run_reg) begin
                if (digit) begin
                    whole_nz_next = whole_nz_reg | (char_code != CH_ZERO);
                end else if (char_code == CH_POINT) begin
                    point_next = 1'b1;
                    run_next = 1'b0;
                end else begin
                    done_next = 1'b1;
                end
            end else if (digit) begin
                run_next = 1'b1;
                whole_nz_next = whole_nz_reg | (char_code != CH_ZERO);
            end else if (char_code == CH_POINT) begin
                point_next = 1'b1;
            end
        end
    end

    // result of the string if this character ends it
    always_comb begin
        len_now   = 5'(pos_reg) + 5'd1;
        named_hit = 1'b0;
        named_rgb = 24'h000000;
        for (int i = NAME_COUNT - 1; i >= 0; i--) begin
            if (mask_next[i] && len_now == 5'(NAME_LEN[i])) begin
                named_hit = 1'b1;
                named_rgb = NAME_RGB[i];
            end
        end

        fin.red        = 8'h00;
        fin.green      = 8'h00;
        fin.blue       = 8'h00;
        fin.form       = FORM_BLACK;
        fin.alpha_full = 1'b1;
        fin.alpha_frac = frac_next;

        priority if (hash_next) begin
            if (pos_reg == 4'd6) begin
                fin.red   = {nib_next[0][3:0], 4'h0} + nib_next[1];
                fin.green = {nib_next[2][3:0], 4'h0} + nib_next[3];
                fin.blue  = {nib_next[4][3:0], 4'h0} + nib_next[5];
                fin.form  = FORM_HEX6;
            end else if (pos_reg == 4'd3) begin
                fin.red   = {nib_next[0][3:0], 4'h0} + nib_next[0];
                fin.green = {nib_next[1][3:0], 4'h0} + nib_next[1];
                fin.blue  = {nib_next[2][3:0], 4'h0} + nib_next[2];
                fin.form  = FORM_HEX3;
            end
        end else if (named_hit) begin
            fin.red   = named_rgb[23:16];
            fin.green = named_rgb[15:8];
            fin.blue  = named_rgb[7:0];
            fin.form  = FORM_NAMED;
        end else if (mask_next[MASK_RGB] && pos_reg >= 4'd3) begin
            fin.red   = comp_next[0];
            fin.green = comp_next[1];
            fin.blue  = comp_next[2];
            fin.form  = FORM_RGB;
        end else if (mask_next[MASK_RGBA] && pos_reg >= 4'd4) begin
            fin.red        = comp_next[0];
            fin.green      = comp_next[1];
            fin.blue       = comp_next[2];
            fin.form       = FORM_RGBA;
            fin.alpha_full = whole_nz_next;
        end else begin
            fin.form = FORM_BLACK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (char_valid && char_last)) begin
            pos_reg      <= 4'd0;
            mask_reg     <= '1;
            hash_reg     <= 1'b0;
            nib_reg      <= '{default: 8'h00};
            comp_reg     <= '{default: 8'h00};
            idx_reg      <= 2'd0;
            run_reg      <= 1'b0;
            whole_nz_reg <= 1'b0;
            point_reg    <= 1'b0;
            done_reg     <= 1'b0;
            frac_reg     <= '0;
            cnt_reg      <= '0;
        end else if (char_valid) begin
            pos_reg      <= pos_next;
            mask_reg     <= mask_next;
            hash_reg     <= hash_next;
            nib_reg      <= nib_next;
            comp_reg     <= comp_next;
            idx_reg      <= idx_next;
            run_reg      <= run_next;
            whole_nz_reg <= whole_nz_next;
            point_reg    <= point_next;
            done_reg     <= done_next;
            frac_reg     <= frac_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[src/css_color_string_parser.sv]
// channel  | dir | tdata                       | tuser        | tlast
// s_       | in  | char_code[7:0]              | -            | last_char
// m_       | out | red, green, blue, alpha     | form_code    | -
//
// one character word per cycle while s_tready is high, no gaps needed between strings
// result is registered after the last character: scan into fin_reg, then alpha scaling into the m_ word
// the alpha stage holds one multiplier (fraction times 255 times reciprocal of the scale)
// aresetn is synchronous, active low; clears the scan state and both stages
// s_tready drops only while a finished string waits behind a stalled m_ word

`default_nettype none

`include "css_color_string_parser_assert.svh"

module css_color_string_parser
    import cssp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output wire logic [2:0]  m_tuser    // [2:0] form_code
);

    fin_t              fin;
    fin_t              fin_reg;
    logic              fin_valid_reg, fin_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg;
    form_t             m_form_reg;
    logic              out_free;
    logic              accept;
    logic [PROD_W-1:0] alpha_prod;
    logic [7:0]        alpha;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !fin_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    cssp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (accept),
        .char_code  (s_tdata),
        .char_last  (s_tlast),
        .fin        (fin)
    );

    assign alpha_prod = PROD_W'(fin_reg.alpha_frac) * PROD_W'(ALPHA_K);
    assign alpha = fin_reg.alpha_full ? 8'hFF : alpha_prod[ALPHA_SHIFT +: 8];

    always_comb begin
        fin_valid_next = fin_valid_reg;
        if (accept && s_tlast) begin
            fin_valid_next = 1'b1;
        end else if (out_free) begin
            fin_valid_next = 1'b0;
        end
        m_valid_next = out_free ? fin_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            fin_valid_reg <= fin_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        if (accept && s_tlast) begin
            fin_reg <= fin;
        end
        if (out_free && fin_valid_reg) begin
            m_data_reg <= {alpha, fin_reg.blue, fin_reg.green, fin_reg.red};
            m_form_reg <= fin_reg.form;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_form_reg;

    `CSSP_ASSERT_NOW(a_hold_input, fin_valid_reg && !out_free, !s_tready)
    `CSSP_ASSERT_NEXT(a_last_loads, s_tvalid && s_tready && s_tlast, fin_valid_reg)
    `CSSP_ASSERT_NEXT(a_drain, m_valid_reg && m_tready && !fin_valid_reg, !m_valid_reg)
    `CSSP_ASSERT_NOW(a_alpha_opaque, m_valid_reg && m_form_reg != FORM_RGBA, m_data_reg[31:24] == 8'hFF)

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb
    import cssp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_NAMES = 16;
    localparam int RGB_BIT = 16;
    localparam int RGBA_BIT = 17;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] ASCII_0 = 8'h30;
    localparam logic [7:0] ASCII_9 = 8'h39;
    localparam logic [7:0] ASCII_DOT = 8'h2E;
    localparam logic [7:0] ASCII_HASH = 8'h23;
    localparam logic [7:0] ASCII_Z = 8'h5A;

    localparam string PFX_RGB = "rgb(";
    localparam string PFX_RGBA = "rgba(";
    localparam string HEX_SET = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } char_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        form_t      form;
    } color_t;

    string color_names [NUM_NAMES] = '{
        "maroon", "red", "orange", "yellow", "olive", "purple", "fuschia", "white",
        "lime", "green", "navy", "blue", "aqua", "teal", "silver", "gray"
    };
    logic [23:0] color_codes [NUM_NAMES] = '{
        24'h800000, 24'hFF0000, 24'hFFA500, 24'hFFFF00,
        24'h808000, 24'h800080, 24'hFF00FF, 24'hFFFFFF,
        24'h00FF00, 24'h008000, 24'h000080, 24'h0000FF,
        24'h00FFFF, 24'h008080, 24'hC0C0C0, 24'h808080
    };
    string separators [8] = '{",", ", ", " ", " , ", ")", "/", "%", "   ,   "};

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;
    wire logic [2:0]  m_tuser;

    css_color_string_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    char_word_t pending_chars[$];
    color_t     expected_colors[$];
    logic [7:0] word_buf[$];

    int error_count = 0;
    int chars_sent = 0;
    int total_chars = 0;
    int strings_built = 0;
    int colors_checked = 0;
    int form_hits [6];
    int idle_cycles = 0;

    // scan state of the predictor
    int          pos_q;
    logic [17:0] match_q;
    bit          hash_q;
    logic [7:0]  nib_q [6];
    logic [7:0]  comp_q [3];
    int          comp_idx_q;
    bit          run_q;
    bit          a_whole_q;
    bit          a_point_q;
    bit          a_done_q;
    int          a_frac_q;
    int          a_cnt_q;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
        logic [7:0] offset;
        if (c >= ASCII_0 && c <= ASCII_9) begin
            offset = ASCII_0;
        end else if (c <= ASCII_Z) begin
            offset = 8'd55;
        end else begin
            offset = 8'd87;
        end
        return c - offset;
    endfunction

    task automatic clear_scan();
        pos_q = 0;
        match_q = '1;
        hash_q = 1'b0;
        foreach (nib_q[i]) nib_q[i] = 8'h00;
        foreach (comp_q[i]) comp_q[i] = 8'h00;
        comp_idx_q = 0;
        run_q = 1'b0;
        a_whole_q = 1'b0;
        a_point_q = 1'b0;
        a_done_q = 1'b0;
        a_frac_q = 0;
        a_cnt_q = 0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic fin);
        int p;
        int v;
        int scale;
        bit digit;
        bit found;
        color_t res;
        p = pos_q;
        digit = (c >= ASCII_0 && c <= ASCII_9);
        if (p == 0 && c == ASCII_HASH) hash_q = 1'b1;
        if (p >= 1 && p <= 6) nib_q[p - 1] = hex_digit_value(c);
        for (int i = 0; i < NUM_NAMES; i++) begin
            if (p >= color_names[i].len() || color_names[i][p] != c) match_q[i] = 1'b0;
        end
        if (p < 4 && PFX_RGB[p] != c) match_q[RGB_BIT] = 1'b0;
        if (p < 5 && PFX_RGBA[p] != c) match_q[RGBA_BIT] = 1'b0;

        // decimal runs, then alpha text for rgba
        if (comp_idx_q < 3) begin
            if (digit) begin
                if (run_q) begin
                    v = comp_q[comp_idx_q];
                    v = v * 10 + (c - ASCII_0);
                    if (v > 255) v = 255;
                end else begin
                    v = c - ASCII_0;
                    run_q = 1'b1;
                end
                comp_q[comp_idx_q] = v[7:0];
            end else if (run_q) begin
                run_q = 1'b0;
                comp_idx_q++;
            end
        end else if (match_q[RGBA_BIT] && !a_done_q) begin
            if (a_point_q) begin
                if (digit) begin
                    if (a_cnt_q < FRACTION_DIGITS) begin
                        a_frac_q = a_frac_q * 10 + (c - ASCII_0);
                        a_cnt_q++;
                    end
                end else begin
                    a_done_q = 1'b1;
                end
            end else if (run_q) begin
                if (digit) begin
                    if (c != ASCII_0) a_whole_q = 1'b1;
                end else if (c == ASCII_DOT) begin
                    a_point_q = 1'b1;
                    run_q = 1'b0;
                end else begin
                    a_done_q = 1'b1;
                end
            end else if (digit) begin
                run_q = 1'b1;
                if (c != ASCII_0) a_whole_q = 1'b1;
            end else if (c == ASCII_DOT) begin
                a_point_q = 1'b1;
            end
        end
        if (pos_q < 15) pos_q++;

        if (fin) begin
            res.red = 8'h00;
            res.green = 8'h00;
            res.blue = 8'h00;
            res.alpha = 8'hFF;
            res.form = FORM_BLACK;
            found = 1'b0;
            if (hash_q) begin
                if (p == 6) begin
                    res.red = (nib_q[0] << 4) + nib_q[1];
                    res.green = (nib_q[2] << 4) + nib_q[3];
                    res.blue = (nib_q[4] << 4) + nib_q[5];
                    res.form = FORM_HEX6;
                end else if (p == 3) begin
                    res.red = nib_q[0] * 8'd17;
                    res.green = nib_q[1] * 8'd17;
                    res.blue = nib_q[2] * 8'd17;
                    res.form = FORM_HEX3;
                end
                found = 1'b1;
            end
            for (int i = 0; i < NUM_NAMES; i++) begin
                if (!found && match_q[i] && p + 1 == color_names[i].len()) begin
                    {res.red, res.green, res.blue} = color_codes[i];
                    res.form = FORM_NAMED;
                    found = 1'b1;
                end
            end
            if (!found && match_q[RGB_BIT] && p >= 3) begin
                {res.red, res.green, res.blue} = {comp_q[0], comp_q[1], comp_q[2]};
                res.form = FORM_RGB;
                found = 1'b1;
            end
            if (!found && match_q[RGBA_BIT] && p >= 4) begin
                {res.red, res.green, res.blue} = {comp_q[0], comp_q[1], comp_q[2]};
                if (!a_whole_q) begin
                    scale = 1;
                    repeat (a_cnt_q) scale = scale * 10;
                    v = a_frac_q * 255 / scale;
                    if (v > 255) v = 255;
                    res.alpha = v[7:0];
                end
                res.form = FORM_RGBA;
            end
            expected_colors.push_back(res);
            form_hits[int'(res.form)]++;
            clear_scan();
        end
    endtask

    task automatic check_color(input logic [31:0] data, input logic [2:0] user);
        color_t want;
        if (expected_colors.size() == 0) begin
            $error("unexpected color word %h, form_code %0d", data, user);
            error_count++;
            return;
        end
        want = expected_colors.pop_front();
        colors_checked++;
        if (data[7:0] !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, data[7:0]);
            error_count++;
        end
        if (data[15:8] !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, data[15:8]);
            error_count++;
        end
        if (data[23:16] !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, data[23:16]);
            error_count++;
        end
        if (data[31:24] !== want.alpha) begin
            $error("alpha mismatch: expected %0d, actual %0d", want.alpha, data[31:24]);
            error_count++;
        end
        if (user !== want.form) begin
            $error("form_code mismatch: expected %0d, actual %0d", want.form, user);
            error_count++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 96) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // string building
    task automatic append_byte(input logic [7:0] b);
        word_buf.push_back(b);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
    endtask

    task automatic end_string();
        foreach (word_buf[i]) begin
            pending_chars.push_back('{code: word_buf[i], is_last: (i == word_buf.size() - 1)});
        end
        if (word_buf.size() > 0) strings_built++;
        word_buf.delete();
    endtask

    task automatic add_string(input string s);
        append_text(s);
        end_string();
    endtask

    task automatic add_hex_digits(input int n);
        repeat (n) begin
            if ($urandom_range(0, 11) == 0) append_byte(8'($urandom_range(0, 255)));
            else append_byte(HEX_SET[$urandom_range(0, HEX_SET.len() - 1)]);
        end
    endtask

    task automatic add_digits(input int n);
        repeat (n) append_byte(8'($urandom_range(ASCII_0, ASCII_9)));
    endtask

    task automatic add_number();
        case ($urandom_range(0, 9))
            6: append_text($sformatf("%0d", $urandom_range(256, 999)));
            7: append_text($sformatf("0%0d", $urandom_range(0, 99)));
            8: append_text($sformatf("%0d", $urandom_range(1000, 99999999)));
            9: append_text("255");
            default: append_text($sformatf("%0d", $urandom_range(0, 255)));
        endcase
    endtask

    task automatic add_separator();
        append_text(separators[$urandom_range(0, 7)]);
    endtask

    task automatic add_alpha();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) append_text(separators[$urandom_range(1, 3)]);
            if ($urandom_range(0, 1) == 0) append_text("x-");
        end
        case ($urandom_range(0, 9))
            0: append_text("1");
            1: append_text("0");
            2: begin
                append_byte(ASCII_DOT);
                add_digits($urandom_range(1, 6));
            end
            3: begin
                append_text("0.");
                add_digits($urandom_range(0, 6));
            end
            4: begin
                append_text($sformatf("%0d", $urandom_range(1, 20)));
                if ($urandom_range(0, 1) == 0) begin
                    append_byte(ASCII_DOT);
                    add_digits($urandom_range(1, 3));
                end
            end
            5: begin
                append_text("00.");
                add_digits($urandom_range(1, 5));
            end
            6: append_text($urandom_range(0, 1) ? "0.9999" : "0.0001");
            default: begin
                append_text("0.");
                add_digits($urandom_range(1, 5));
            end
        endcase
        case ($urandom_range(0, 3))
            0: append_text(")");
            1: append_text(")xyz.5");
            2: append_text(" 5");
            default: ;
        endcase
    endtask

    task automatic add_components(input int n);
        for (int i = 0; i < n; i++) begin
            add_number();
            if (i < n - 1) add_separator();
        end
    endtask

    task automatic add_random_string();
        int r;
        int n;
        string s;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            append_byte(ASCII_HASH);
            add_hex_digits(6);
        end else if (r < 25) begin
            append_byte(ASCII_HASH);
            add_hex_digits(3);
        end else if (r < 32) begin
            n = $urandom_range(0, 12);
            if (n == 3 || n == 6) n++;
            append_byte(ASCII_HASH);
            add_hex_digits(n);
        end else if (r < 47) begin
            s = color_names[$urandom_range(0, NUM_NAMES - 1)];
            case ($urandom_range(0, 9))
                0: s = {s, "e"};
                1: s = s.substr(0, s.len() - 2);
                2: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(8'h61, 8'h7A));
                3: s = s.toupper();
                default: ;
            endcase
            append_text(s);
        end else if (r < 65) begin
            append_text(PFX_RGB);
            if ($urandom_range(0, 3) == 0) append_text("  ");
            add_components(($urandom_range(0, 99) < 85) ? 3 : $urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: append_text(") 7 8");
                1: ;
                default: append_text(")");
            endcase
        end else if (r < 85) begin
            append_text(PFX_RGBA);
            if ($urandom_range(0, 3) == 0) append_byte(" ");
            add_components(3);
            add_separator();
            add_alpha();
        end else if (r < 95) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 12);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
        end else begin
            s = ($urandom_range(0, 1) == 0) ? PFX_RGB : PFX_RGBA;
            append_text(s.substr(0, $urandom_range(0, s.len() - 2)));
            append_byte(8'($urandom_range(0, 255)));
            add_components($urandom_range(1, 3));
            append_text(")");
        end
        end_string();
    endtask

    // driver
    char_word_t next_word;
    int src_gap = 0;
    int src_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
            src_gap = 0;
            src_calm = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tlast);
                chars_sent++;
            end
            if (src_calm > 0) src_calm--;
            else if ($urandom_range(0, 299) == 0) src_calm = $urandom_range(100, 300);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    next_word = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.code;
                    s_tlast <= next_word.is_last;
                    src_gap = (src_calm > 0) ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int sink_stall = 0;
    int sink_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall = 0;
            sink_calm = 0;
        end else begin
            if (m_tvalid && m_tready) check_color(m_tdata, m_tuser);
            if (sink_calm > 0) sink_calm--;
            else if ($urandom_range(0, 299) == 0) sink_calm = $urandom_range(100, 300);
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_calm == 0 && $urandom_range(0, 2) == 0) sink_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_scan();
        foreach (form_hits[i]) form_hits[i] = 0;

        // directed strings
        add_string("#000000");
        add_string("#FFffFF");
        add_string("#f0a");
        add_string("#");
        add_string("#12345");
        add_string("#gz!x~Q");
        add_string("fuschia");
        add_string("fuchsia");
        add_string("silver");
        add_string("redd");
        add_string("maroonmaroon");
        add_string("rgb(255,0,128)");
        add_string("rgb(1000,256,99999)");
        add_string("rgb(");
        add_string("rgb(   1,    2,     3)");
        add_string("rgba(10,20,30,0.5)");
        add_string("rgba(1,2,3,1)");
        add_string("rgba(1,2,3,.123456)");
        add_string("rgba(4,5,6, x0.25)");
        add_string("rgba(0,0,0,0)");
        add_string("rgba(9,9,9,00.9999)");
        append_byte(8'h00);
        end_string();
        append_byte(8'hFF);
        end_string();

        // every named color at least once, then random strings
        foreach (color_names[i]) add_string(color_names[i]);
        while (pending_chars.size() < 1400) add_random_string();
        total_chars = pending_chars.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (chars_sent < total_chars) @(posedge aclk);
        while (expected_colors.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_colors.size() > 0) begin
            $error("%0d expected colors never arrived", expected_colors.size());
            error_count++;
        end
        $display("sent %0d strings in %0d characters, checked %0d colors",
                 strings_built, total_chars, colors_checked);
        $display("forms: hex6 %0d, hex3 %0d, named %0d, rgb %0d, rgba %0d, black %0d",
                 form_hits[0], form_hits[1], form_hits[2], form_hits[3], form_hits[4],
                 form_hits[5]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
